// ===== rtl/tsa_pkg.sv =====
// Package for the two-task assigner: operation, status and task codes,
// sequencer state type and the age unit control struct. No dependencies.
package tsa_pkg;

    localparam int DEF_MAX_ITEMS = 64;
    localparam int DEF_MAX_EDGES = 1024;
    localparam int AGE_ADDR_W    = 10;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SOLVE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOSOL = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic [1:0] TASK_A = 2'd0;
    localparam logic [1:0] TASK_B = 2'd1;
    localparam logic [1:0] TASK_C = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_AGE_WR, S_CF_YA, S_CF_YB, S_CF_CHK, S_E_RD, S_E_WR,
        S_RD_Y, S_SV_ITEM, S_W_MARK, S_W_PUSH, S_W_LOOP, S_W_POP, S_W_EDGE,
        S_RB_RD, S_RB_CLR, S_DONE
    } t_state;

    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic                  clr;
        logic [AGE_ADDR_W-1:0] addr;
        logic [15:0]           wdata;
    } t_age_ctl;

endpackage

// ===== rtl/tsa_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
interface tsa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [6:0]  first_index;
    logic [6:0]  second_index;
    logic [15:0] age_value;
    modport source(output valid, operation, first_index, second_index, age_value,
                   input ready);
    modport sink(input valid, operation, first_index, second_index, age_value,
                 output ready);
endinterface

interface tsa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] task_res;
    modport source(output valid, status, task_res, input ready);
    modport sink(input valid, status, task_res, output ready);
endinterface

// ===== rtl/two_sat_task_assigner_unit.sv =====
// Two-task assigner top level: request decoder, graph memories and the
// depth-first solve sequencer. Depends on tsa_pkg, tsa_if, tsa_age_unit.
//
// Usage: requests arrive on i_req (operation, indexes, age), one response
// per request leaves on o_rsp (status, task_res). Both are valid/ready.
// item_count is written over the APB port at byte address 0; the user
// must write it only while idle, the block does not enforce this. Clear,
// out-of-range and undefined requests go from dispatch to the output
// register; set age and read task pass an age-write or task-read state;
// add conflict reads both ages, checks for room, then writes its edges.
// Solve runs a marking walk through the list-head, edge, trail and stack
// memories, so its run time depends on the graph. One request is in flight
// at a time; i_req.ready is high only in the idle state. A finished
// response waits in the output register; while o_rsp is stalled the next
// request may be accepted and worked on, and its response is held until
// the register frees. Reset: item_count goes to 1, marks, edges and lists
// are emptied; ages read as zero until set.
module two_sat_task_assigner_unit #(
    parameter int MAX_ITEMS = tsa_pkg::DEF_MAX_ITEMS,
    parameter int MAX_EDGES = tsa_pkg::DEF_MAX_EDGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsa_req_if.sink       i_req,
    tsa_rsp_if.source     o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [0:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tsa_pkg::*;

    localparam int LIT_COUNT = 2 * MAX_ITEMS + 2;
    localparam int LW  = $clog2(LIT_COUNT);
    localparam int DW  = $clog2(LIT_COUNT + 1);
    localparam int EPW = $clog2(MAX_EDGES + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int IW  = $clog2(MAX_ITEMS + 2);
    localparam logic [EPW-1:0] EDGE_NONE = EPW'(MAX_EDGES);

    t_state r_state, n_state;

    logic [2:0]           r_op;
    logic [6:0]           r_a, r_b, r_count;
    logic [15:0]          r_age;
    logic [LIT_COUNT-1:0] r_mark, r_hvalid;
    logic                 r_hv, r_sf, r_ya, r_yb, r_same, r_phase;
    logic [EPW-1:0]       r_etot, r_cur_e;
    logic [1:0]           r_k, r_st, r_tk;
    logic [IW-1:0]        r_i;
    logic [LW-1:0]        r_v;
    logic [DW-1:0]        r_depth, r_tl;
    logic                 r_ovalid;
    logic [1:0]           r_ostatus, r_otask;

    // Memories
    logic [EPW-1:0]    r_lh_mem [LIT_COUNT];
    logic [LW+EPW-1:0] r_em_mem [MAX_EDGES];
    logic [LW-1:0]     r_tr_mem [LIT_COUNT];
    logic [EPW-1:0]    r_sk_mem [LIT_COUNT];
    logic [EPW-1:0]    lh_rd, sk_rd;
    logic [LW+EPW-1:0] em_rd;
    logic [LW-1:0]     tr_rd;

    logic           lh_re, lh_we, em_re, em_we, tr_re, tr_we, sk_re, sk_we;
    logic [LW-1:0]  lh_ra, lh_wa, tr_ra, sk_ra, sk_wa;
    logic [EW-1:0]  em_ra;
    t_age_ctl       age_ctl;
    logic           younger;

    logic [IW-1:0]  n_eff;
    logic           a_ok, b_ok, accept, cfg_wr, out_free;
    logic [LW-1:0]  la0, la1, lb0, lb1, e_from, e_to, it_lo, it_hi;
    logic           v_out, v_set, v_neg, v_fresh, e_none, it_done, it_skip;
    logic           edge_full, e_last;
    logic [EPW-1:0] head;

    always_comb begin
        if (r_count == 7'd0) begin
            n_eff = IW'(1);
        end else if (32'(r_count) > MAX_ITEMS) begin
            n_eff = IW'(MAX_ITEMS);
        end else begin
            n_eff = IW'(r_count);
        end
    end

    assign a_ok   = (r_a != 7'd0) && (32'(r_a) <= 32'(n_eff));
    assign b_ok   = (r_b != 7'd0) && (32'(r_b) <= 32'(n_eff));
    assign accept = i_req.valid && i_req.ready;
    assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
    assign out_free = !r_ovalid || o_rsp.ready;

    assign la0 = LW'({r_a, 1'b0});
    assign la1 = la0 | LW'(1);
    assign lb0 = LW'({r_b, 1'b0});
    assign lb1 = lb0 | LW'(1);
    assign it_lo = LW'({r_i, 1'b0});
    assign it_hi = it_lo | LW'(1);

    always_comb begin
        case (r_k)
            2'd0:    begin e_from = la0; e_to = lb1; end
            2'd1:    begin e_from = lb0; e_to = la1; end
            2'd2:    begin e_from = la1; e_to = lb0; end
            default: begin e_from = lb1; e_to = la0; end
        endcase
    end

    assign v_out   = 32'(r_v) >= LIT_COUNT;
    assign v_set   = !v_out && r_mark[r_v];
    assign v_neg   = !v_out && r_mark[r_v ^ LW'(1)];
    assign v_fresh = !v_out && !v_set && !v_neg;
    assign e_none  = r_cur_e >= EDGE_NONE;
    assign head    = r_hv ? lh_rd : EDGE_NONE;
    assign it_done = 32'(r_i) > 32'(n_eff);
    assign it_skip = r_mark[it_hi] || r_mark[it_lo];
    assign edge_full = (32'(r_etot) + ((r_ya == r_yb) ? 32'd4 : 32'd2)) > 32'(MAX_EDGES);
    assign e_last  = r_k == (r_same ? 2'd3 : 2'd1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (accept) n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (r_op)
                    OP_SET:   n_state = a_ok ? S_AGE_WR : S_DONE;
                    OP_ADD:   n_state = (a_ok && b_ok) ? S_CF_YA : S_DONE;
                    OP_SOLVE: n_state = S_SV_ITEM;
                    OP_READ:  n_state = a_ok ? S_RD_Y : S_DONE;
                    default:  n_state = S_DONE;
                endcase
            end
            S_AGE_WR:   n_state = S_DONE;
            S_CF_YA:    n_state = S_CF_YB;
            S_CF_YB:    n_state = S_CF_CHK;
            S_CF_CHK:   n_state = edge_full ? S_DONE : S_E_RD;
            S_E_RD:     n_state = S_E_WR;
            S_E_WR:     n_state = e_last ? S_DONE : S_E_RD;
            S_RD_Y:     n_state = S_DONE;
            S_SV_ITEM: begin
                if (it_done) n_state = S_DONE;
                else if (!it_skip) n_state = S_W_MARK;
            end
            S_W_MARK: begin
                if (v_out || v_set) n_state = S_W_LOOP;
                else if (v_neg) n_state = r_phase ? S_DONE : S_RB_RD;
                else n_state = S_W_PUSH;
            end
            S_W_PUSH:   n_state = S_W_LOOP;
            S_W_LOOP: begin
                if (r_depth == '0) n_state = S_SV_ITEM;
                else if (e_none) n_state = (r_depth > DW'(1)) ? S_W_POP : S_W_LOOP;
                else n_state = S_W_EDGE;
            end
            S_W_POP:    n_state = S_W_LOOP;
            S_W_EDGE:   n_state = S_W_MARK;
            S_RB_RD:    n_state = (r_tl == '0) ? S_W_MARK : S_RB_CLR;
            S_RB_CLR:   n_state = S_RB_RD;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory and age unit controls
    always_comb begin
        age_ctl = '0;
        lh_re = 1'b0; lh_ra = e_from;
        lh_we = 1'b0; lh_wa = e_from;
        em_re = 1'b0; em_ra = r_cur_e[EW-1:0];
        em_we = 1'b0;
        tr_re = 1'b0; tr_ra = LW'(r_tl - DW'(1));
        tr_we = 1'b0;
        sk_re = 1'b0; sk_ra = LW'(r_depth - DW'(2));
        sk_we = 1'b0; sk_wa = LW'(r_depth - DW'(1));
        unique case (r_state)
            S_DISPATCH: begin
                age_ctl.clr  = r_op == OP_CLEAR;
                age_ctl.rd   = a_ok;
                age_ctl.addr = AGE_ADDR_W'(r_a - 7'd1);
            end
            S_AGE_WR: begin
                age_ctl.wr    = 1'b1;
                age_ctl.addr  = AGE_ADDR_W'(r_a - 7'd1);
                age_ctl.wdata = r_age;
            end
            S_CF_YA: begin
                age_ctl.rd   = 1'b1;
                age_ctl.addr = AGE_ADDR_W'(r_b - 7'd1);
            end
            S_E_RD: lh_re = 1'b1;
            S_E_WR: begin
                lh_we = 1'b1;
                em_we = 1'b1;
            end
            S_W_MARK: begin
                lh_ra = r_v;
                lh_re = v_fresh;
                tr_we = v_fresh && (32'(r_tl) < LIT_COUNT);
            end
            S_W_PUSH: sk_we = r_depth != '0;
            S_W_LOOP: begin
                if (r_depth != '0) begin
                    if (e_none) sk_re = r_depth > DW'(1);
                    else em_re = 1'b1;
                end
            end
            S_RB_RD: tr_re = r_tl != '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lh_we) r_lh_mem[lh_wa] <= r_etot;
        if (lh_re) lh_rd <= r_lh_mem[lh_ra];
    end

    always_ff @(posedge i_clk) begin
        if (em_we) r_em_mem[r_etot[EW-1:0]] <= {e_to, head};
        if (em_re) em_rd <= r_em_mem[em_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tr_we) r_tr_mem[LW'(r_tl)] <= r_v;
        if (tr_re) tr_rd <= r_tr_mem[tr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sk_we) r_sk_mem[sk_wa] <= r_cur_e;
        if (sk_re) sk_rd <= r_sk_mem[sk_ra];
    end

    tsa_age_unit #(.MAX_ITEMS(MAX_ITEMS)) u_age (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (age_ctl),
        .i_count   (n_eff),
        .o_younger (younger)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= 7'd1;
            r_mark   <= '0;
            r_hvalid <= '0;
            r_etot   <= '0;
            r_sf     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_count <= pwdata[6:0];
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_DISPATCH: begin
                    if (r_op == OP_CLEAR) begin
                        r_mark   <= '0;
                        r_hvalid <= '0;
                        r_etot   <= '0;
                        r_sf     <= 1'b0;
                    end else if (r_op == OP_SOLVE) begin
                        r_mark <= '0;
                    end
                end
                S_AGE_WR: r_sf <= 1'b0;
                S_E_WR: begin
                    r_hvalid[e_from] <= 1'b1;
                    r_etot <= r_etot + EPW'(1);
                    if (e_last) r_sf <= 1'b0;
                end
                S_SV_ITEM: if (it_done) r_sf <= 1'b1;
                S_W_MARK: begin
                    if (v_fresh) r_mark[r_v] <= 1'b1;
                    if (!v_out && !v_set && v_neg && r_phase) r_sf <= 1'b0;
                end
                S_RB_CLR: if (32'(tr_rd) < LIT_COUNT) r_mark[tr_rd] <= 1'b0;
                default: ;
            endcase
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.operation;
            r_a   <= i_req.first_index;
            r_b   <= i_req.second_index;
            r_age <= i_req.age_value;
        end
        if (r_state == S_DONE && out_free) begin
            r_ostatus <= r_st;
            r_otask   <= r_tk;
        end
        case (r_state)
            S_DISPATCH: begin
                r_st <= STAT_OK;
                r_tk <= TASK_A;
                r_i  <= IW'(1);
            end
            S_CF_YA: r_ya <= younger;
            S_CF_YB: r_yb <= younger;
            S_CF_CHK: begin
                r_same <= r_ya == r_yb;
                r_k    <= 2'd0;
                if (edge_full) r_st <= STAT_FULL;
            end
            S_E_RD: r_hv <= r_hvalid[e_from];
            S_E_WR: r_k <= r_k + 2'd1;
            S_RD_Y: begin
                if (r_mark[la0]) r_tk <= TASK_C;
                else if (younger) r_tk <= TASK_B;
                else r_tk <= TASK_A;
                r_st <= r_sf ? STAT_OK : STAT_NOSOL;
            end
            S_SV_ITEM: begin
                if (!it_done) begin
                    if (it_skip) begin
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_tl    <= '0;
                        r_v     <= it_hi;
                        r_phase <= 1'b0;
                        r_depth <= '0;
                    end
                end
            end
            S_W_MARK: begin
                if (v_fresh) begin
                    r_hv <= r_hvalid[r_v];
                    if (32'(r_tl) < LIT_COUNT) r_tl <= r_tl + DW'(1);
                end
                if (!v_out && !v_set && v_neg && r_phase) r_st <= STAT_NOSOL;
            end
            S_W_PUSH: begin
                r_cur_e <= head;
                r_depth <= r_depth + DW'(1);
            end
            S_W_LOOP: begin
                if (r_depth == '0) r_i <= r_i + IW'(1);
                else if (e_none) r_depth <= r_depth - DW'(1);
            end
            S_W_POP: r_cur_e <= sk_rd;
            S_W_EDGE: begin
                r_cur_e <= em_rd[EPW-1:0];
                r_v     <= em_rd[LW+EPW-1:EPW];
            end
            S_RB_RD: begin
                if (r_tl == '0) begin
                    r_v     <= it_lo;
                    r_phase <= 1'b1;
                    r_depth <= '0;
                end else begin
                    r_tl <= r_tl - DW'(1);
                end
            end
            default: ;
        endcase
    end

    assign i_req.ready    = r_state == S_IDLE;
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.status   = r_ostatus;
    assign o_rsp.task_res = r_otask;
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {25'd0, r_count} : 32'd0;

endmodule

// ===== rtl/tsa_age_unit.sv =====
// Age store, running age total and the shared multiply-compare that
// classifies an item as younger. Depends on tsa_pkg.
module tsa_age_unit #(
    parameter int MAX_ITEMS = tsa_pkg::DEF_MAX_ITEMS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsa_pkg::t_age_ctl                i_ctl,
    input  logic [$clog2(MAX_ITEMS+2)-1:0]   i_count,
    output logic                             o_younger
);
    import tsa_pkg::*;

    localparam int IW  = $clog2(MAX_ITEMS + 2);
    localparam int IXW = $clog2(MAX_ITEMS);
    localparam int PW  = 16 + IW;

    logic [15:0]          r_mem [MAX_ITEMS];
    logic [15:0]          r_rd;
    logic [PW-1:0]        r_total;
    logic [MAX_ITEMS-1:0] r_aval;
    logic                 r_rd_v;
    logic [15:0]          old_age;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd <= r_mem[i_ctl.addr[IXW-1:0]];
        end
        if (i_ctl.wr) begin
            r_mem[i_ctl.addr[IXW-1:0]] <= i_ctl.wdata;
        end
    end

    // A slot not written since reset or clear counts as age zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aval <= '0;
            r_rd_v <= 1'b0;
        end else begin
            if (i_ctl.rd) begin
                r_rd_v <= r_aval[i_ctl.addr[IXW-1:0]];
            end
            if (i_ctl.clr) begin
                r_aval <= '0;
            end else if (i_ctl.wr) begin
                r_aval[i_ctl.addr[IXW-1:0]] <= 1'b1;
            end
        end
    end

    assign old_age = r_rd_v ? r_rd : 16'd0;

    // Replace the old age in the total; old age was fetched the cycle before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_ctl.clr) begin
            r_total <= '0;
        end else if (i_ctl.wr) begin
            r_total <= r_total - PW'(old_age) + PW'(i_ctl.wdata);
        end
    end

    assign o_younger = (PW'(old_age) * PW'(i_count)) < r_total;

endmodule

// ===== rtl/tsa_checker.sv =====
// Port-level checks for the two-task assigner, bound to the top level.
// Depends on tsa_pkg and two_sat_task_assigner_unit.
module tsa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_status,
    input logic [1:0] out_task
);
    import tsa_pkg::*;

    // One transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one still running");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_task))
        else $error("stalled response changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_status != 2'd3 && out_task != 2'd3)
        else $error("illegal response code");

    // Only a read reports a task, and a read never reports a full edge table
    a_task_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_task != TASK_A |-> out_status != STAT_FULL)
        else $error("task reported with edge-full status");

endmodule

bind two_sat_task_assigner_unit tsa_checker u_tsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_req.valid),
    .in_ready   (i_req.ready),
    .out_valid  (o_rsp.valid),
    .out_ready  (o_rsp.ready),
    .out_status (o_rsp.status),
    .out_task   (o_rsp.task_res)
);

// ===== sim/two_sat_task_assigner_unit_test.sv =====
// Self-checking testbench for two_sat_task_assigner_unit: directed table, then
// random clear/age/conflict/solve/read sequences checked against a 2-SAT predictor.
// Depends on tsa_pkg, tsa_if and the RTL top level.
module two_sat_task_assigner_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tsa_pkg::*;

    localparam int         NITEMS   = 64;
    localparam int         NEDGES   = 1024;
    localparam int         NLITS    = 2 * NITEMS + 2;
    localparam int         WDOG_MAX = 1000000;
    localparam logic [2:0] OP_UNDEF = 3'd5;
    localparam logic [2:0] OP_TOP   = 3'd7;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] task_res;
    } t_answer;

    typedef struct {
        logic [2:0]  op;
        logic [6:0]  a;
        logic [6:0]  b;
        logic [15:0] age;
        bit          typed;
        t_answer     ans;
    } t_row;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    tsa_req_if req ();
    tsa_rsp_if rsp ();

    two_sat_task_assigner_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req.sink), .o_rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // assigner state as the predictor sees it
    logic [6:0]  cfg_count;
    logic [15:0] item_age [1:NITEMS];
    bit          age_known [1:NITEMS];
    logic [21:0] age_sum;
    bit          lit_mark [0:NLITS-1];
    int          trail [0:NLITS-1];
    int          trail_len;
    int          edge_to [0:NEDGES-1];
    int          edge_next [0:NEDGES-1];
    int          head [0:NLITS-1];
    int          edge_cnt;
    int          stk_lit [0:NLITS-1];
    int          stk_edge [0:NLITS-1];
    bit          solved;

    t_answer answer_q[$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      sent = 0;

    function automatic int items_in_use();
        if (cfg_count < 1) return 1;
        if (cfg_count > NITEMS) return NITEMS;
        return cfg_count;
    endfunction

    function automatic bit is_younger(int i);
        return 32'(item_age[i]) * items_in_use() < 32'(age_sum);
    endfunction

    function automatic void wipe_graph();
        for (int i = 1; i <= NITEMS; i++) begin
            item_age[i] = '0;
            age_known[i] = 0;
        end
        for (int i = 0; i < NLITS; i++) begin
            lit_mark[i] = 0;
            head[i] = NEDGES;
        end
        age_sum = '0;
        trail_len = 0;
        edge_cnt = 0;
        solved = 0;
    endfunction

    function automatic void link_edge(int from, int to);
        edge_to[edge_cnt] = to;
        edge_next[edge_cnt] = head[from];
        head[from] = edge_cnt;
        edge_cnt++;
    endfunction

    function automatic bit mark_literal(int v, inout int depth);
        if (v >= NLITS || lit_mark[v]) return 1;
        if (lit_mark[v ^ 1]) return 0;
        lit_mark[v] = 1;
        if (trail_len < NLITS) begin
            trail[trail_len] = v;
            trail_len++;
        end
        if (depth < NLITS) begin
            stk_lit[depth] = v;
            stk_edge[depth] = head[v];
            depth++;
        end
        return 1;
    endfunction

    function automatic bit propagate(int root);
        int depth = 0;
        int e;
        if (!mark_literal(root, depth)) return 0;
        while (depth > 0) begin
            e = stk_edge[depth-1];
            if (e >= NEDGES) begin
                depth--;
            end else begin
                stk_edge[depth-1] = edge_next[e];
                if (!mark_literal(edge_to[e], depth)) return 0;
            end
        end
        return 1;
    endfunction

    function automatic bit assign_all();
        int n = items_in_use();
        for (int i = 0; i < NLITS; i++) lit_mark[i] = 0;
        for (int i = 1; i <= n; i++) begin
            if (!lit_mark[2*i+1] && !lit_mark[2*i]) begin
                trail_len = 0;
                if (!propagate(2*i+1)) begin
                    while (trail_len > 0) begin
                        trail_len--;
                        lit_mark[trail[trail_len] % NLITS] = 0;
                    end
                    if (!propagate(2*i)) return 0;
                end
            end
        end
        return 1;
    endfunction

    function automatic t_answer assigner_step(logic [2:0] op, int a, int b, logic [15:0] age);
        t_answer r = '0;
        int  n = items_in_use();
        bit  a_ok = a >= 1 && a <= n;
        bit  b_ok = b >= 1 && b <= n;
        bit  same;
        case (op)
            OP_CLEAR: wipe_graph();
            OP_SET: if (a_ok) begin
                age_sum = age_sum - item_age[a] + age;
                item_age[a] = age;
                age_known[a] = 1;
                solved = 0;
            end
            OP_ADD: if (a_ok && b_ok) begin
                same = is_younger(a) == is_younger(b);
                if (edge_cnt + (same ? 4 : 2) > NEDGES) begin
                    r.status = STAT_FULL;
                end else begin
                    link_edge(2*a, 2*b+1);
                    link_edge(2*b, 2*a+1);
                    if (same) begin
                        link_edge(2*a+1, 2*b);
                        link_edge(2*b+1, 2*a);
                    end
                    solved = 0;
                end
            end
            OP_SOLVE: begin
                solved = assign_all();
                r.status = solved ? STAT_OK : STAT_NOSOL;
            end
            OP_READ: if (a_ok) begin
                r.task_res = lit_mark[2*a] ? TASK_C : (is_younger(a) ? TASK_B : TASK_A);
                r.status = solved ? STAT_OK : STAT_NOSOL;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // response side: stall at random
    initial begin
        int stall;
        rsp.ready = 0;
        @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                rsp.ready <= 0;
                repeat (stall) @(negedge i_clk);
            end
            rsp.ready <= 1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (answer_q.size() == 0) begin
                $error("response with nothing expected: status %0d task_res %0d",
                       rsp.status, rsp.task_res);
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.task_res !== want.task_res) begin
                    $error("task_res: expected %0d, got %0d", want.task_res, rsp.task_res);
                    errors++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(logic [2:0] op, logic [6:0] a, logic [6:0] b, logic [15:0] age,
                        bit typed = 0, t_answer ans = '0);
        int g = pick_gap();
        t_answer got;
        if (g > 0) begin
            req.valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        req.valid <= 1;
        req.operation <= op;
        req.first_index <= a;
        req.second_index <= b;
        req.age_value <= age;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        got = assigner_step(op, a, b, age);
        answer_q.insert(answer_q.size(), typed ? ans : got);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_count(logic [6:0] val);
        drain();
        psel <= 1;
        pwrite <= 1;
        paddr <= '0;
        pwdata <= {25'd0, val};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        cfg_count = val;
    endtask

    function automatic logic [15:0] pick_age();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_known(int n);
        int i;
        repeat (40) begin
            i = $urandom_range(1, n);
            if (age_known[i]) return i;
        end
        return 0;
    endfunction

    // occasional ignored or out-of-range request
    task automatic send_noise(int n);
        case ($urandom_range(0, 2))
            0: send(3'($urandom_range(OP_UNDEF, OP_TOP)), 7'($urandom), 7'($urandom), 16'($urandom));
            1: send(OP_SET, 7'($urandom_range(n + 1, 127)), 7'($urandom), 16'($urandom));
            default: send($urandom_range(0, 1) ? OP_ADD : OP_READ, 7'($urandom_range(n + 1, 127)),
                          7'($urandom), 16'($urandom));
        endcase
    endtask

    task automatic run_phase(int adds, bit hold_once);
        int n = items_in_use();
        int a, b;
        int hold_at = $urandom_range(0, adds);
        send(OP_CLEAR, 7'($urandom), 7'($urandom), 16'($urandom));
        for (int i = 1; i <= n; i++) begin
            send(OP_SET, 7'(i), 7'($urandom), pick_age());
            if ($urandom_range(0, 9) == 0) send_noise(n);
        end
        for (int k = 0; k < adds; k++) begin
            if (hold_once && k == hold_at) begin
                req.valid <= 0;
                while (answer_q.size() != 0) @(negedge i_clk);
            end
            a = pick_known(n);
            b = pick_known(n);
            if (a != 0 && b != 0) send(OP_ADD, 7'(a), 7'(b), 16'($urandom));
            if ($urandom_range(0, 9) == 0) send_noise(n);
        end
        for (int pass = 0; pass < 2; pass++) begin
            send(OP_SOLVE, 7'($urandom), 7'($urandom), 16'($urandom));
            for (int i = 1; i <= n; i++) if (age_known[i]) send(OP_READ, 7'(i), 7'($urandom), 16'($urandom));
            // change an age and look again without solving
            a = pick_known(n);
            if (a != 0) begin
                send(OP_SET, 7'(a), 7'($urandom), pick_age());
                send(OP_READ, 7'(a), 7'($urandom), 16'($urandom));
            end
        end
    endtask

    t_row plan[$];

    function automatic void add_row(t_row row);
        plan.insert(plan.size(), row);
    endfunction

    initial begin
        int n;
        req.valid = 0;
        req.operation = OP_CLEAR;
        req.first_index = '0;
        req.second_index = '0;
        req.age_value = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        cfg_count = 7'd1;
        wipe_graph();
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // one item after reset
        add_row('{OP_READ, 7'd0, 7'd0, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_UNDEF, 7'd1, 7'd1, 16'd1, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_TOP, 7'd127, 7'd127, 16'hFFFF, 1, '{STAT_OK, TASK_A}});
        add_row('{3'd6, 7'd64, 7'd64, 16'h8000, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_SOLVE, 7'd0, 7'd0, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_SET, 7'd1, 7'd0, 16'hFFFF, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_SET, 7'd2, 7'd0, 16'd1, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_SET, 7'd127, 7'd0, 16'd7, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_READ, 7'd1, 7'd0, 16'd0, 1, '{STAT_NOSOL, TASK_A}});
        add_row('{OP_SOLVE, 7'd0, 7'd0, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_READ, 7'd1, 7'd0, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_READ, 7'd64, 7'd0, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_ADD, 7'd1, 7'd2, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_ADD, 7'd0, 7'd1, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_ADD, 7'd1, 7'd1, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_SOLVE, 7'd0, 7'd0, 16'd0, 1, '{STAT_NOSOL, TASK_A}});
        add_row('{OP_READ, 7'd1, 7'd0, 16'd0, 0, '0});
        add_row('{OP_SET, 7'd1, 7'd0, 16'h1234, 0, '0});
        add_row('{OP_SOLVE, 7'd0, 7'd0, 16'd0, 0, '0});
        add_row('{OP_CLEAR, 7'd0, 7'd0, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_SET, 7'd1, 7'd0, 16'd0, 1, '{STAT_OK, TASK_A}});
        add_row('{OP_READ, 7'd1, 7'd0, 16'd0, 1, '{STAT_NOSOL, TASK_A}});
        foreach (plan[i]) send(plan[i].op, plan[i].a, plan[i].b, plan[i].age, plan[i].typed,
                               plan[i].ans);

        // count extremes, then fill the edge table once
        write_count(7'd0);
        run_phase(3, 1);
        write_count(7'd127);
        run_phase(40, 0);
        write_count(7'd64);
        run_phase(330, 1);
        write_count(7'd2);
        run_phase(4, 0);
        while (sent < 1450) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            write_count(7'(n));
            run_phase($urandom_range(0, 3 * n), $urandom_range(0, 3) == 0);
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
